[hdl/apc_pkg.sv]
// ----------------------------------------------------------------------------
// apc_pkg: shared types and constants of the angle PID controller
// Widths, fixed-point constants, register codes, sequencer states and the
// command and status words between the controller and its serial units.
// ----------------------------------------------------------------------------
package apc_pkg;

  // Default fraction width of the angles.
  localparam int ANGLE_FRAC_BITS_DEF = 8;

  // Fixed field widths.
  localparam int ANGLE_W    = 18;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 31;
  localparam int DRIVE_W    = 32;
  localparam int INTEG_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Filtered error range.
  localparam int ERR_MAX  = 131071;
  localparam int ERR_MIN  = -131072;
  localparam int ERR_BIAS = 131072;

  // Divide-by-ten unit: the biased numerator is always positive and below 2^22.
  localparam int DIVISOR    = 10;
  localparam int DIV_ROUND  = 5;
  localparam int DIV_OFFSET = DIVISOR * ERR_BIAS;
  localparam int DIV_W      = 22;
  localparam int DIV_REM_W  = 4;

  // Multiply-accumulate unit.
  localparam int MUL_X_W     = ANGLE_W + 1;
  localparam int ACC_W       = 36;
  localparam int SUM_W       = INTEG_W + 2;
  localparam int ROUND_SHIFT = 8;
  localparam int ROUND_HALF  = 128;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P         = 3'd0,
    REG_GAIN_I         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_INTEGRAL_LIMIT = 3'd3,
    REG_OUTPUT_LIMIT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_DIV,
    ST_MUL_I,
    ST_INT,
    ST_MUL_P,
    ST_MUL_D,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    logic accumulate;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

[hdl/apc_div10.sv]
// ----------------------------------------------------------------------------
// apc_div10: bit-serial divider by ten
// Restoring division of an unsigned dividend, one quotient bit per cycle.
// The quotient replaces the dividend in the same shift register.
// ----------------------------------------------------------------------------
module apc_div10
  import apc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   dividend_i,
  output logic [DIV_W-1:0]   quotient_o,
  output unit_status_t       status_o
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0]     shift_q, shift_d;
  logic [DIV_REM_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [DIV_REM_W:0]   trial;
  logic                 fits;
  logic                 last;

  assign trial = {rem_q, shift_q[DIV_W-1]};
  assign fits  = trial >= (DIV_REM_W+1)'(DIVISOR);
  assign last  = cnt_q == CNT_W'(DIV_W - 1);

  always_comb begin
    rem_d   = fits ? DIV_REM_W'(trial - (DIV_REM_W+1)'(DIVISOR)) : trial[DIV_REM_W-1:0];
    shift_d = {shift_q[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shift_q <= dividend_i;
      rem_q   <= '0;
    end else if (busy_q) begin
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

  assign quotient_o = shift_q;
  assign status_o   = '{busy: busy_q, done: done_q};

endmodule

[hdl/apc_mac.sv]
// ----------------------------------------------------------------------------
// apc_mac: bit-serial multiply-accumulate unit
// Takes one bit of the signed gain per cycle, least significant first, and
// adds the shifted multiplicand; the sign bit of the gain subtracts.
// ----------------------------------------------------------------------------
module apc_mac
  import apc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mac_cmd_t                  cmd_i,
  input  logic signed [MUL_X_W-1:0] x_i,
  input  logic signed [GAIN_W-1:0]  gain_i,
  output logic signed [ACC_W-1:0]   acc_o,
  output unit_status_t              status_o
);

  localparam int CNT_W = $clog2(GAIN_W);

  logic signed [ACC_W-1:0] x_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [GAIN_W-1:0]       gain_q;
  logic [CNT_W-1:0]        cnt_q;
  logic                    busy_q, done_q;
  logic signed [ACC_W-1:0] addend;
  logic                    last;

  assign last   = cnt_q == CNT_W'(GAIN_W - 1);
  assign addend = gain_q[0] ? x_q : '0;

  // The top bit of a two's complement gain weighs negative.
  always_comb begin
    acc_d = last ? acc_q - addend : acc_q + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q    <= ACC_W'(x_i);
      gain_q <= gain_i;
      if (!cmd_i.accumulate) begin
        acc_q <= '0;
      end
    end else if (busy_q) begin
      x_q    <= x_q <<< 1;
      gain_q <= gain_q >> 1;
      acc_q  <= acc_d;
    end
  end

  assign acc_o    = acc_q;
  assign status_o = '{busy: busy_q, done: done_q};

endmodule

[hdl/angle_pid_controller.sv]
// ----------------------------------------------------------------------------
// angle_pid_controller: PID controller on a wrapped, low-pass filtered angle
// One word at a time: from accept to result the controller runs the 360-degree
// wrap steps (none to three at eight fraction bits), the 22-step divide by ten
// and three 16-step passes of the shared bit-serial multiplier. A waiting
// result does not block the next accept. Reset clears the gains, limits,
// previous error and integral to zero.
// ----------------------------------------------------------------------------
module angle_pid_controller
  import apc_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [ANGLE_W-1:0] measured_angle_i,
  input  logic signed [ANGLE_W-1:0] target_angle_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DRIVE_W-1:0] drive_o
);

  localparam int WRAP_W = (((10 + ANGLE_FRAC_BITS) > (ANGLE_W + 1)) ?
                           (10 + ANGLE_FRAC_BITS) : (ANGLE_W + 1)) + 1;
  localparam logic signed [WRAP_W-1:0] HALF     = WRAP_W'(180 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [WRAP_W-1:0] NEG_HALF = WRAP_W'(-180 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [WRAP_W-1:0] FULL     = WRAP_W'(360 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [WRAP_W-1:0] ERR_HI   = WRAP_W'(ERR_MAX);
  localparam logic signed [WRAP_W-1:0] ERR_LO   = WRAP_W'(ERR_MIN);

  function automatic logic signed [INTEG_W-1:0] clamp_sym(
    input logic signed [SUM_W-1:0] v,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] r;
    hi = SUM_W'(lim);
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[INTEG_W-1:0];
  endfunction

  // Configuration registers.
  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_W-1:0]       integral_limit_q, output_limit_q;

  // Controller state and working registers.
  state_e                    state_q, state_d;
  logic signed [WRAP_W-1:0]  err_q, err_d;
  logic signed [ANGLE_W-1:0] f_q;
  logic signed [ANGLE_W-1:0] prev_q;
  logic signed [INTEG_W-1:0] integral_q;
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      out_valid_q;

  // Datapath.
  logic                      err_low, err_high, err_ok;
  logic signed [ANGLE_W-1:0] err_sat;
  logic signed [DIV_W:0]     numer;
  logic [DIV_W-1:0]          quotient;
  logic signed [ANGLE_W-1:0] f_now;
  logic signed [MUL_X_W-1:0] delta;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_biased;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [SUM_W-1:0]   sum_pre;
  logic signed [INTEG_W-1:0] sum_clamped;
  unit_status_t              div_status, mac_status;

  // Control outputs of the sequencer.
  logic                      accept;
  logic                      div_start;
  mac_cmd_t                  mac_cmd;
  logic signed [MUL_X_W-1:0] mac_x;
  logic signed [GAIN_W-1:0]  mac_gain;
  logic                      take_f;
  logic                      load_integral;
  logic                      load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q         <= '0;
      gain_i_q         <= '0;
      gain_d_q         <= '0;
      integral_limit_q <= '0;
      output_limit_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_P:         gain_p_q         <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_I:         gain_i_q         <= cfg_wdata_i[GAIN_W-1:0];
        REG_GAIN_D:         gain_d_q         <= cfg_wdata_i[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        REG_OUTPUT_LIMIT:   output_limit_q   <= cfg_wdata_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Wrap step: one add or subtract of a full turn per cycle.
  assign err_low  = err_q < NEG_HALF;
  assign err_high = err_q > HALF;
  assign err_ok   = !err_low && !err_high;

  always_comb begin
    if (accept) begin
      err_d = WRAP_W'(measured_angle_i) - WRAP_W'(target_angle_i);
    end else if (err_low) begin
      err_d = err_q + FULL;
    end else if (err_high) begin
      err_d = err_q - FULL;
    end else begin
      err_d = err_q;
    end
  end

  always_comb begin
    if (err_q > ERR_HI) begin
      err_sat = ANGLE_W'(ERR_MAX);
    end else if (err_q < ERR_LO) begin
      err_sat = ANGLE_W'(ERR_MIN);
    end else begin
      err_sat = err_q[ANGLE_W-1:0];
    end
  end

  // Biased so the numerator of the filter is positive; the bias comes off the
  // quotient again as ERR_BIAS.
  assign numer = (DIV_W+1)'(err_sat) + ((DIV_W+1)'(prev_q) <<< 3) + (DIV_W+1)'(prev_q)
               + (DIV_W+1)'(DIV_ROUND + DIV_OFFSET);

  apc_div10 u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (numer[DIV_W-1:0]),
    .quotient_o (quotient),
    .status_o   (div_status)
  );

  assign f_now = ANGLE_W'(quotient - DIV_W'(ERR_BIAS));
  assign delta = MUL_X_W'(f_q) - MUL_X_W'(prev_q);

  apc_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (mac_cmd),
    .x_i      (mac_x),
    .gain_i   (mac_gain),
    .acc_o    (acc),
    .status_o (mac_status)
  );

  // Round to nearest on the Q8.8 gain scale, ties toward plus infinity.
  assign acc_biased  = acc + ACC_W'(ROUND_HALF);
  assign acc_rnd     = acc_biased >>> ROUND_SHIFT;
  assign sum_pre     = SUM_W'(integral_q) + SUM_W'(acc_rnd);
  assign sum_clamped = clamp_sym(sum_pre, load_out ? output_limit_q : integral_limit_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_WRAP;
      ST_WRAP:  if (err_ok) state_d = ST_DIV;
      ST_DIV:   if (div_status.done) state_d = ST_MUL_I;
      ST_MUL_I: if (mac_status.done) state_d = ST_INT;
      ST_INT:   state_d = ST_MUL_P;
      ST_MUL_P: if (mac_status.done) state_d = ST_MUL_D;
      ST_MUL_D: if (mac_status.done) state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o    = 1'b1;
    accept        = 1'b0;
    div_start     = 1'b0;
    mac_cmd       = '{start: 1'b0, accumulate: 1'b0};
    mac_x         = MUL_X_W'(f_q);
    mac_gain      = gain_p_q;
    take_f        = 1'b0;
    load_integral = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        accept     = in_valid_i;
      end
      ST_WRAP: begin
        div_start = err_ok;
      end
      ST_DIV: begin
        take_f        = div_status.done;
        mac_cmd.start = div_status.done;
        mac_x         = MUL_X_W'(f_now);
        mac_gain      = gain_i_q;
      end
      ST_INT: begin
        load_integral = 1'b1;
        mac_cmd.start = 1'b1;
      end
      ST_MUL_P: begin
        mac_cmd = '{start: mac_status.done, accumulate: 1'b1};
        mac_x   = delta;
        mac_gain = gain_d_q;
      end
      ST_OUT: begin
        load_out = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      integral_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_integral) begin
        integral_q <= sum_clamped;
      end
      if (load_out) begin
        prev_q      <= f_q;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    err_q <= err_d;
    if (take_f) begin
      f_q <= f_now;
    end
    if (load_out) begin
      drive_q <= sum_clamped;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // An accepted word closes the input until its result is formed.
  a_stall_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input open right after an accept");

  // The divider and the multiplier never run at the same time.
  a_units_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({div_status.busy, mac_status.busy}))
    else $error("divider and multiplier busy together");

  a_integral_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_P) |->
      (integral_q <= $signed({1'b0, integral_limit_q}) &&
       integral_q >= -$signed({1'b0, integral_limit_q})))
    else $error("integral outside its limit");

  a_drive_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      (drive_q <= $signed({1'b0, output_limit_q}) &&
       drive_q >= -$signed({1'b0, output_limit_q})))
    else $error("drive outside the output limit");

endmodule
